/* src/sfmf_pkg.sv */
// ---------------------------------------------------------------------------
// sfmf_pkg
// shared types and constants for the substring first-match finder
// ---------------------------------------------------------------------------
package sfmf_pkg;

   // sizing
   localparam int PATTERN_MAX    = 8;
   localparam int POSITION_BITS  = 16;
   localparam int INDEX_BITS     = 16;
   localparam int BYTE_BITS      = 8;
   localparam int LEN_BITS       = 4;
   localparam int PATTERN_BITS   = 64;
   localparam int PATTERN_LANES  = PATTERN_BITS / BYTE_BITS;
   localparam int LANE_BITS      = $clog2(PATTERN_LANES);
   localparam int WIDE_BITS      = (POSITION_BITS > INDEX_BITS) ? POSITION_BITS : INDEX_BITS;

   // input queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // csr register indexes
   typedef enum logic [0:0] {
      CSR_PATTERN_BYTES  = 1'b0,
      CSR_PATTERN_LENGTH = 1'b1
   } csr_index_type;

   // one text byte as it travels through the queue
   typedef struct packed {
      logic                 last_byte;
      logic [BYTE_BITS-1:0] text_byte;
   } item_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // one search result
   typedef struct packed {
      logic [INDEX_BITS-1:0] end_index;
      logic [INDEX_BITS-1:0] start_index;
      logic                  found;
   } result_type;

endpackage

/* src/sfmf_front.sv */
// ---------------------------------------------------------------------------
// sfmf_front
// accepts text byte transactions and holds them in a short queue
// ---------------------------------------------------------------------------
module sfmf_front
   import sfmf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [BYTE_BITS-1:0] in_byte,
   input  logic                 in_last,
   output head_type             head,
   input  logic                 pop
);

   item_type                  store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push;
   logic                      do_pop;

   assign in_ready = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign push     = in_valid && in_ready;
   assign do_pop   = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= '{last_byte: in_last, text_byte: in_byte};
      end
   end

endmodule

/* src/sfmf_back.sv */
// ---------------------------------------------------------------------------
// sfmf_back
// shift window, parallel pattern compare and registered result
// ---------------------------------------------------------------------------
module sfmf_back
   import sfmf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [PATTERN_BITS-1:0] pattern_bytes,
   input  logic [LEN_BITS-1:0]     pattern_length,
   input  head_type                head,
   output logic                    pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output result_type              out_result
);

   logic [BYTE_BITS-1:0]     window_ff [PATTERN_MAX];
   logic [BYTE_BITS-1:0]     window_in [PATTERN_MAX];
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_next;
   logic                     reported_ff, reported_in;
   logic                     out_valid_ff, out_valid_in;
   result_type               result_ff, result_in;
   logic [LEN_BITS-1:0]      len;
   logic [LEN_BITS-1:0]      lane_idx;
   logic [BYTE_BITS-1:0]     lanes [PATTERN_LANES];
   logic [BYTE_BITS-1:0]     shifted [PATTERN_MAX];
   logic                     match;
   logic                     emit;
   logic [WIDE_BITS-1:0]     start_wide;
   logic [WIDE_BITS-1:0]     end_wide;

   // room in the output register, or it empties this cycle
   assign pop        = head.valid && (!out_valid_ff || out_ready);
   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

   assign len = (pattern_length > LEN_BITS'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX)
                                                          : pattern_length;

   always_comb begin
      for (int k = 0; k < PATTERN_LANES; k++) begin
         lanes[k] = pattern_bytes[k*BYTE_BITS +: BYTE_BITS];
      end
   end

   // window with the new byte shifted in at entry 0
   always_comb begin
      shifted[0] = head.item.text_byte;
      for (int i = 1; i < PATTERN_MAX; i++) begin
         shifted[i] = window_ff[i-1];
      end
   end

   assign pos_next = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;

   always_comb begin
      match    = (len != '0) && (pos_next >= POSITION_BITS'(len));
      lane_idx = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         lane_idx = len - LEN_BITS'(1) - LEN_BITS'(j);
         if ((LEN_BITS'(j) < len) && (shifted[j] != lanes[lane_idx[LANE_BITS-1:0]])) begin
            match = 1'b0;
         end
      end
   end

   assign start_wide = WIDE_BITS'(pos_next - POSITION_BITS'(len));
   assign end_wide   = WIDE_BITS'(pos_next);

   always_comb begin
      window_in    = window_ff;
      pos_in       = pos_ff;
      reported_in  = reported_ff;
      out_valid_in = out_valid_ff && !out_ready;
      result_in    = result_ff;
      emit         = 1'b0;
      if (pop) begin
         if (!reported_ff) begin
            window_in = shifted;
            pos_in    = pos_next;
            if (match) begin
               reported_in           = 1'b1;
               emit                  = 1'b1;
               result_in.found       = 1'b1;
               result_in.start_index = start_wide[INDEX_BITS-1:0];
               result_in.end_index   = end_wide[INDEX_BITS-1:0];
            end else if (head.item.last_byte) begin
               emit      = 1'b1;
               result_in = '0;
            end
         end
         if (head.item.last_byte) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
               window_in[i] = '0;
            end
            pos_in      = '0;
            reported_in = 1'b0;
         end
         if (emit) begin
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PATTERN_MAX; i++) begin
            window_ff[i] <= '0;
         end
         pos_ff       <= '0;
         reported_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         pos_ff       <= pos_in;
         reported_ff  <= reported_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

/* src/substring_first_match_finder_top.sv */
// ---------------------------------------------------------------------------
// substring_first_match_finder_top
// finds the first occurrence of a configured pattern in a byte stream
// ---------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// req_      in         req_tvalid/req_tready  tdata = text_byte, tlast = last_byte
// rsp_      out        rsp_tvalid/rsp_tready  tuser = found, tdata = start/end index
// csr_      in         csr_valid/csr_ready    csr_index selects register, csr_data
//
// one text byte per cycle sustained while no result waits on rsp_tready; a byte
// is written into the queue and compared at the queue head, and the first match
// or a stream's last byte registers a result that drives rsp_tvalid
// reset is synchronous and clears queue, window, position and the csr registers
// the two-entry queue lets the front keep taking bytes while the result
// register waits on rsp_tready; req_tready drops only when the queue is full
// csr writes are always taken and must only happen while the block is idle
// ---------------------------------------------------------------------------
module substring_first_match_finder_top
   import sfmf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   // text byte stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [BYTE_BITS-1:0]      req_tdata,   // [7:0] text_byte
   input  logic                      req_tlast,   // last_byte

   // search results
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [2*INDEX_BITS-1:0]   rsp_tdata,   // [15:0] start_index, [31:16] end_index
   output logic [0:0]                rsp_tuser,   // [0] found

   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [0:0]                csr_index,
   input  logic [PATTERN_BITS-1:0]   csr_data
);

   logic [PATTERN_BITS-1:0] pattern_bytes_ff;
   logic [LEN_BITS-1:0]     pattern_length_ff;
   head_type                head;
   logic                    pop;
   result_type              result;
   csr_index_type           csr_sel;

   // register port never stalls
   assign csr_ready = 1'b1;
   assign csr_sel   = csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff  <= '0;
         pattern_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_sel)
            CSR_PATTERN_BYTES:  pattern_bytes_ff  <= csr_data;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // front: take byte transactions into the queue
   sfmf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .head     (head),
      .pop      (pop)
   );

   // back: window shift, compare, result register
   sfmf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pattern_bytes  (pattern_bytes_ff),
      .pattern_length (pattern_length_ff),
      .head           (head),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_result     (result)
   );

   // result packing, start index in the low half
   assign rsp_tdata = {result.end_index, result.start_index};
   assign rsp_tuser = result.found;

endmodule
